@@ design/nearest_neighbour_tour_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbour tour core
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOUR_TOUR_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOUR_TOUR_CORE_DEFINES_SVH

// same-cycle implication
`define NNT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NNT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication
`define NNT_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ design/nnt_pkg.sv @@
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types, codes and constants of the nearest-neighbour tour core.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int NODE_W   = 4;
  localparam int WEIGHT_W = 10;
  localparam int COST_W   = 14;
  localparam int CNT_W    = 5;

  // node indices are 4 bits wide, so no more than 16 nodes ever take part
  localparam int HW_NODE_LIMIT = 16;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [COST_W-1:0]   cost_t;
  typedef logic [CNT_W-1:0]    count_t;

  localparam weight_t NO_EDGE_LIMIT  = weight_t'(999);
  localparam cost_t   COST_MAX       = '1;
  localparam count_t  NODE_COUNT_RST = count_t'(16);
  localparam count_t  NODE_COUNT_MIN = count_t'(2);

  // input word kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_RUN   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_STEP,
    ST_FINISH,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } nnt_state_t;

  // weight matrix access from the sequencer
  typedef struct packed {
    logic    wr_en;
    node_t   wr_row;
    node_t   wr_col;
    weight_t wr_data;
    logic    rd_en;
    node_t   rd_row;
    node_t   rd_col;
  } mat_req_t;

  // path store access: two banks, current walk and best walk
  typedef struct packed {
    logic  wr_en;
    logic  wr_bank;
    node_t wr_pos;
    node_t wr_node;
    logic  rd_en;
    logic  rd_bank;
    node_t rd_pos;
  } path_req_t;

endpackage

@@ design/nnt_in_if.sv @@
// ----------------------------------------------------------------------------
// nnt_in_if
// Input channel: matrix weight writes and run commands.
// ----------------------------------------------------------------------------
interface nnt_in_if import nnt_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    kind;
  node_t   row;
  node_t   col;
  weight_t weight;

  modport source (output valid, kind, row, col, weight, input ready);
  modport sink   (input valid, kind, row, col, weight, output ready);
endinterface

@@ design/nnt_out_if.sv @@
// ----------------------------------------------------------------------------
// nnt_out_if
// Result channel: nodes of the best path with its cost.
// ----------------------------------------------------------------------------
interface nnt_out_if import nnt_pkg::*; ();
  logic  valid;
  logic  ready;
  node_t node;
  node_t position;
  cost_t total_cost;
  logic  found;
  logic  last;

  modport source (output valid, node, position, total_cost, found, last, input ready);
  modport sink   (input valid, node, position, total_cost, found, last, output ready);
endinterface

@@ design/nnt_matrix.sv @@
// ----------------------------------------------------------------------------
// nnt_matrix
// Weight matrix memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nnt_matrix import nnt_pkg::*; #(
  parameter int NODES_LIM = 16
) (
  input  logic     clk,
  input  mat_req_t req,
  output weight_t  rdata
);

  localparam int IDX_W = $clog2(NODES_LIM);
  localparam int DEPTH = 1 << (2 * IDX_W);

  weight_t mem_r [DEPTH];
  weight_t rdata_r;
  logic    wr_in_range;

  // writes to rows or columns past the node limit are dropped
  assign wr_in_range = (count_t'({1'b0, req.wr_row}) < count_t'(NODES_LIM)) &&
                       (count_t'({1'b0, req.wr_col}) < count_t'(NODES_LIM));

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem_r[{req.wr_row[IDX_W-1:0], req.wr_col[IDX_W-1:0]}] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem_r[{req.rd_row[IDX_W-1:0], req.rd_col[IDX_W-1:0]}];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/nnt_paths.sv @@
// ----------------------------------------------------------------------------
// nnt_paths
// Two-bank path store; a bank flip keeps the best walk without copying.
// ----------------------------------------------------------------------------
module nnt_paths import nnt_pkg::*; #(
  parameter int NODES_LIM = 16
) (
  input  logic      clk,
  input  path_req_t req,
  output node_t     rdata
);

  localparam int IDX_W = $clog2(NODES_LIM);
  localparam int DEPTH = 2 << IDX_W;

  node_t mem_r [DEPTH];
  node_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[{req.wr_bank, req.wr_pos[IDX_W-1:0]}] <= req.wr_node;
    end
    if (req.rd_en) begin
      rdata_r <= mem_r[{req.rd_bank, req.rd_pos[IDX_W-1:0]}];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/nnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// nnt_ctrl
// Walk sequencer: scans matrix rows, picks the nearest node, tracks best.
// ----------------------------------------------------------------------------
module nnt_ctrl import nnt_pkg::*; #(
  parameter int NODES_LIM = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  nnt_in_if.sink            in_bus,
  nnt_out_if.source         out_bus,
  input  count_t            n_active,
  output mat_req_t          mat_req,
  input  weight_t           mat_rdata,
  output path_req_t         path_req,
  input  node_t             path_rdata
);

  localparam int IDX_W = $clog2(NODES_LIM);

  nnt_state_t state_r, state_nxt;

  count_t                 n_r, n_nxt;
  node_t                  s_r, s_nxt;
  node_t                  j_r, j_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  node_t                  rd_j_r, rd_j_nxt;
  node_t                  last_r, last_nxt;
  count_t                 len_r, len_nxt;
  cost_t                  cost_r, cost_nxt;
  logic [NODES_LIM-1:0]   visited_r, visited_nxt;
  node_t                  pick_r, pick_nxt;
  weight_t                pick_w_r, pick_w_nxt;
  logic                   pick_ok_r, pick_ok_nxt;
  logic                   best_valid_r, best_valid_nxt;
  cost_t                  best_cost_r, best_cost_nxt;
  logic                   cur_bank_r, cur_bank_nxt;
  logic                   best_bank_r, best_bank_nxt;
  node_t                  k_r, k_nxt;

  node_t                  last_j;
  logic                   path_done;
  logic                   run_acc;
  logic                   take;
  logic                   emit_last;
  logic [COST_W:0]        cost_sum;
  cost_t                  cost_sat;

  assign last_j    = node_t'(n_r - count_t'(1));
  assign path_done = (count_t'(len_r + count_t'(1)) == n_r);
  assign run_acc   = in_bus.valid && (in_bus.kind == KIND_RUN);
  assign emit_last = !best_valid_r || (k_r == last_j);

  // candidate check on the weight that just came back from the matrix
  assign take = rd_vld_r && (mat_rdata != '0) && (mat_rdata < pick_w_r) &&
                !visited_r[rd_j_r[IDX_W-1:0]];

  assign cost_sum = {1'b0, cost_r} + {{(COST_W-WEIGHT_W+1){1'b0}}, pick_w_r};
  assign cost_sat = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (run_acc) state_nxt = ST_START;
      ST_START:    state_nxt = ST_SCAN;
      ST_SCAN:     if (j_r == last_j) state_nxt = ST_DRAIN;
      ST_DRAIN:    state_nxt = ST_STEP;
      ST_STEP: begin
        if (!pick_ok_r || path_done) state_nxt = ST_FINISH;
        else state_nxt = ST_SCAN;
      end
      ST_FINISH: begin
        if (s_r == last_j) state_nxt = ST_EMIT_RD;
        else state_nxt = ST_START;
      end
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_bus.ready) state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // handshake, payload and memory requests
  always_comb begin
    in_bus.ready       = (state_r == ST_IDLE);
    out_bus.valid      = (state_r == ST_EMIT_OUT);
    out_bus.node       = best_valid_r ? path_rdata : '0;
    out_bus.position   = best_valid_r ? k_r : '0;
    out_bus.total_cost = best_valid_r ? best_cost_r : '0;
    out_bus.found      = best_valid_r;
    out_bus.last       = emit_last;

    mat_req.wr_en   = (state_r == ST_IDLE) && in_bus.valid && (in_bus.kind == KIND_WRITE);
    mat_req.wr_row  = in_bus.row;
    mat_req.wr_col  = in_bus.col;
    mat_req.wr_data = in_bus.weight;
    mat_req.rd_en   = (state_r == ST_SCAN);
    mat_req.rd_row  = last_r;
    mat_req.rd_col  = j_r;

    path_req.wr_en   = (state_r == ST_START) || ((state_r == ST_STEP) && pick_ok_r);
    path_req.wr_bank = cur_bank_r;
    path_req.wr_pos  = (state_r == ST_START) ? '0 : node_t'(len_r);
    path_req.wr_node = (state_r == ST_START) ? s_r : pick_r;
    path_req.rd_en   = (state_r == ST_EMIT_RD);
    path_req.rd_bank = best_bank_r;
    path_req.rd_pos  = k_r;
  end

  // datapath next values
  always_comb begin
    n_nxt          = n_r;
    s_nxt          = s_r;
    j_nxt          = j_r;
    rd_vld_nxt     = (state_r == ST_SCAN);
    rd_j_nxt       = j_r;
    last_nxt       = last_r;
    len_nxt        = len_r;
    cost_nxt       = cost_r;
    visited_nxt    = visited_r;
    pick_nxt       = pick_r;
    pick_w_nxt     = pick_w_r;
    pick_ok_nxt    = pick_ok_r;
    best_valid_nxt = best_valid_r;
    best_cost_nxt  = best_cost_r;
    cur_bank_nxt   = cur_bank_r;
    best_bank_nxt  = best_bank_r;
    k_nxt          = k_r;

    if (take) begin
      pick_w_nxt  = mat_rdata;
      pick_nxt    = rd_j_r;
      pick_ok_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (run_acc) begin
          n_nxt          = n_active;
          s_nxt          = '0;
          best_valid_nxt = 1'b0;
          best_cost_nxt  = COST_MAX;
        end
      end
      ST_START: begin
        visited_nxt                   = '0;
        visited_nxt[s_r[IDX_W-1:0]]   = 1'b1;
        last_nxt                      = s_r;
        len_nxt                       = count_t'(1);
        cost_nxt                      = '0;
        j_nxt                         = '0;
        pick_w_nxt                    = NO_EDGE_LIMIT;
        pick_ok_nxt                   = 1'b0;
      end
      ST_SCAN: j_nxt = node_t'(j_r + node_t'(1));
      ST_STEP: begin
        if (pick_ok_r) begin
          visited_nxt[pick_r[IDX_W-1:0]] = 1'b1;
          last_nxt    = pick_r;
          cost_nxt    = cost_sat;
          len_nxt     = count_t'(len_r + count_t'(1));
          j_nxt       = '0;
          pick_w_nxt  = NO_EDGE_LIMIT;
          pick_ok_nxt = 1'b0;
        end
      end
      ST_FINISH: begin
        // complete walk that beats the best so far takes over its bank
        if ((len_r == n_r) && (!best_valid_r || (cost_r < best_cost_r))) begin
          best_valid_nxt = 1'b1;
          best_cost_nxt  = cost_r;
          best_bank_nxt  = cur_bank_r;
          cur_bank_nxt   = !cur_bank_r;
        end
        if (s_r == last_j) k_nxt = '0;
        else s_nxt = node_t'(s_r + node_t'(1));
      end
      ST_EMIT_OUT: begin
        if (out_bus.ready && !emit_last) k_nxt = node_t'(k_r + node_t'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      best_valid_r <= 1'b0;
      best_cost_r  <= COST_MAX;
      cur_bank_r   <= 1'b0;
      best_bank_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_valid_r <= best_valid_nxt;
      best_cost_r  <= best_cost_nxt;
      cur_bank_r   <= cur_bank_nxt;
      best_bank_r  <= best_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    s_r       <= s_nxt;
    j_r       <= j_nxt;
    rd_j_r    <= rd_j_nxt;
    last_r    <= last_nxt;
    len_r     <= len_nxt;
    cost_r    <= cost_nxt;
    visited_r <= visited_nxt;
    pick_r    <= pick_nxt;
    pick_w_r  <= pick_w_nxt;
    pick_ok_r <= pick_ok_nxt;
    k_r       <= k_nxt;
  end

endmodule

@@ design/nearest_neighbour_tour_core.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_core
// Greedy nearest-neighbour path search over a loaded weight matrix.
// in_bus words: kind 0 writes weight[row][col], one per idle cycle, no result;
//   kind 1 runs a greedy walk from every start node over the first n nodes.
// out_bus words: the cheapest complete path, one word per node with position,
//   total_cost and found, last set on the final word; a single word with
//   found 0 when no start reaches every node. cfg_we/cfg_wdata set node_count.
// Sequence: each walk step reads one matrix row, one weight per cycle on the
//   matrix read port, then settles the pick in states DRAIN and STEP. After a
//   run, each result word needs a path store read, then the word is held
//   until taken.
// in_bus.ready is low from a run command until its last word is taken; a
//   receiver stall simply holds the current word. Reset idles the sequencer,
//   sets node_count to 16; the matrix keeps no reset and must be loaded.
// ----------------------------------------------------------------------------
`include "nearest_neighbour_tour_core_defines.svh"

module nearest_neighbour_tour_core import nnt_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  nnt_in_if.sink        in_bus,
  nnt_out_if.source     out_bus,
  input  logic          cfg_we,
  input  count_t        cfg_wdata
);

  // nodes that can take part: bounded by the parameter and the 4-bit index
  localparam int NODES_LIM = (MAX_NODES < HW_NODE_LIMIT) ? MAX_NODES : HW_NODE_LIMIT;

  count_t    node_count_r, node_count_nxt;
  count_t    n_active;
  mat_req_t  mat_req;
  weight_t   mat_rdata;
  path_req_t path_req;
  node_t     path_rdata;

  // node count register, to be written only while idle; the block itself does not enforce it
  assign node_count_nxt = cfg_we ? cfg_wdata : node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  // clamp to [2, NODES_LIM]; latched by the sequencer at run start
  always_comb begin
    if (node_count_r < NODE_COUNT_MIN) begin
      n_active = NODE_COUNT_MIN;
    end else if (node_count_r > count_t'(NODES_LIM)) begin
      n_active = count_t'(NODES_LIM);
    end else begin
      n_active = node_count_r;
    end
  end

  nnt_ctrl #(
    .NODES_LIM (NODES_LIM)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .n_active   (n_active),
    .mat_req    (mat_req),
    .mat_rdata  (mat_rdata),
    .path_req   (path_req),
    .path_rdata (path_rdata)
  );

  nnt_matrix #(
    .NODES_LIM (NODES_LIM)
  ) u_matrix (
    .clk   (clk),
    .req   (mat_req),
    .rdata (mat_rdata)
  );

  nnt_paths #(
    .NODES_LIM (NODES_LIM)
  ) u_paths (
    .clk   (clk),
    .req   (path_req),
    .rdata (path_rdata)
  );

  // input side and result side are never open together
  `NNT_ASSERT_IMP(a_no_overlap, in_bus.ready, !out_bus.valid, "input open while a result is pending")

  // a run command closes the input on the next cycle
  `NNT_ASSERT_NXT(a_run_blocks, in_bus.valid && in_bus.ready && (in_bus.kind == KIND_RUN), !in_bus.ready, "input still open after run command")

  // the not-found word is the only word of its run
  `NNT_ASSERT_IMP(a_empty_last, out_bus.valid && !out_bus.found, out_bus.last && (out_bus.position == '0), "not-found word is not a lone last word")

  // path words come out in order
  `NNT_ASSERT_DLY2(a_pos_step, out_bus.valid && out_bus.ready && !out_bus.last, out_bus.valid && (out_bus.position == node_t'($past($past(out_bus.position)) + 1'b1)), "path position did not advance by one")

endmodule

@@ tb/nnt_tour_checker.sv @@
// ----------------------------------------------------------------------------
// nnt_tour_checker
// Watches the word channels of the tour core, keeps its own copy of the
// weight matrix and node count, predicts the best greedy path for each run
// command and compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nnt_tour_checker import nnt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  nnt_in_if      in_mon,
  nnt_out_if     out_mon,
  input  logic   cfg_we,
  input  count_t cfg_wdata,
  output int     pending_words,
  output int     fail_count
);

  typedef struct packed {
    node_t node;
    node_t position;
    cost_t total_cost;
    logic  found;
    logic  last;
  } tour_word_t;

  weight_t    weight_mem [HW_NODE_LIMIT][HW_NODE_LIMIT];
  count_t     node_setting = NODE_COUNT_RST;
  tour_word_t tour_q [$];
  int         errors = 0;

  initial begin
    pending_words = 0;
    fail_count    = 0;
  end

  // out-of-range counts clamp to [2, 16]
  function automatic int active_nodes();
    if (node_setting < NODE_COUNT_MIN) begin
      return NODE_COUNT_MIN;
    end
    if (node_setting > HW_NODE_LIMIT) begin
      return HW_NODE_LIMIT;
    end
    return node_setting;
  endfunction

  // greedy walk from every start; cheapest complete path wins, lowest start on a tie
  function automatic void predict_tour();
    int          n;
    int          len;
    int          pick;
    int          walk_cost;
    int          best_cost;
    bit          have_best;
    bit          stuck;
    logic [15:0] seen;
    weight_t     pick_w;
    weight_t     w;
    node_t       walk [HW_NODE_LIMIT];
    node_t       best [HW_NODE_LIMIT];
    tour_word_t  word;
    n = active_nodes();
    have_best = 1'b0;
    best_cost = COST_MAX;
    for (int s = 0; s < n; s++) begin
      seen      = 16'(1) << s;
      walk[0]   = node_t'(s);
      len       = 1;
      walk_cost = 0;
      stuck     = 1'b0;
      while (len < n && !stuck) begin
        pick   = n;
        pick_w = NO_EDGE_LIMIT;
        for (int j = 0; j < n; j++) begin
          w = weight_mem[walk[len-1]][j];
          if (w != 0 && w < pick_w && !seen[j]) begin
            pick_w = w;
            pick   = j;
          end
        end
        if (pick >= n) begin
          stuck = 1'b1;
        end else begin
          seen[pick] = 1'b1;
          walk[len]  = node_t'(pick);
          len++;
          walk_cost += pick_w;
          if (walk_cost > COST_MAX) begin
            walk_cost = COST_MAX;
          end
        end
      end
      if (len == n && (!have_best || walk_cost < best_cost)) begin
        have_best = 1'b1;
        best_cost = walk_cost;
        best      = walk;
      end
    end
    if (!have_best) begin
      word = '{node: '0, position: '0, total_cost: '0, found: 1'b0, last: 1'b1};
      tour_q.push_back(word);
    end else begin
      for (int k = 0; k < n; k++) begin
        word.node       = best[k];
        word.position   = node_t'(k);
        word.total_cost = cost_t'(best_cost);
        word.found      = 1'b1;
        word.last       = (k == n - 1);
        tour_q.push_back(word);
      end
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("ERROR %0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_word();
    tour_word_t want;
    if (tour_q.size() == 0) begin
      $display("ERROR %0t: result word node %0d position %0d with nothing outstanding",
               $time, out_mon.node, out_mon.position);
      errors++;
    end else begin
      want = tour_q.pop_front();
      check_field("node",       want.node,       out_mon.node);
      check_field("position",   want.position,   out_mon.position);
      check_field("total_cost", want.total_cost, out_mon.total_cost);
      check_field("found",      want.found,      out_mon.found);
      check_field("last",       want.last,       out_mon.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tour_q.delete();
      node_setting = NODE_COUNT_RST;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_word();
      end
      if (cfg_we) begin
        node_setting = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_WRITE) begin
          weight_mem[in_mon.row][in_mon.col] = in_mon.weight;
        end else begin
          predict_tour();
        end
      end
    end
    pending_words <= tour_q.size();
    fail_count    <= errors;
  end

endmodule

@@ tb/tb_nearest_neighbour_tour_core.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_neighbour_tour_core
// Drives weight writes and run commands into the tour core with bursty
// offers, stalls the result side on a shifting pattern (with one long
// hold-off at least), steps node_count through small values, below the
// minimum included, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_neighbour_tour_core import nnt_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;
  int     pending_words;
  int     fail_count;
  int     cycle_count = 0;

  // sender burst bookkeeping
  int     burst_left = 0;
  // active node span and which matrix entries hold a known weight;
  // a run must never read an entry that was not written since power-up
  int     span = HW_NODE_LIMIT;
  bit     loaded [HW_NODE_LIMIT][HW_NODE_LIMIT];

  nnt_in_if  in_bus ();
  nnt_out_if out_bus ();

  nearest_neighbour_tour_core #(
    .MAX_NODES (16)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nnt_tour_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pending_words (pending_words),
    .fail_count    (fail_count)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one word and hold it until taken. Bursts end with a random gap;
  // a zero gap keeps valid high straight into the next burst.
  task automatic push_word(input logic kind, input node_t row, input node_t col,
                           input weight_t weight);
    int gap;
    in_bus.valid  <= 1'b1;
    in_bus.kind   <= kind;
    in_bus.row    <= row;
    in_bus.col    <= col;
    in_bus.weight <= weight;
    do @(posedge clk); while (!in_bus.ready);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_weight(input int row, input int col, input weight_t weight);
    push_word(KIND_WRITE, node_t'(row), node_t'(col), weight);
    loaded[row][col] = 1'b1;
  endtask

  // run command; the other fields carry noise the core must ignore
  task automatic run_tour();
    push_word(KIND_RUN, node_t'($urandom_range(0, 15)), node_t'($urandom_range(0, 15)),
              weight_t'($urandom_range(0, 1023)));
  endtask

  // Mostly usable weights, small ones often so ties show up; some no-edge
  // zeros and some values at or above the 999 cutoff.
  function automatic weight_t pick_weight();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) begin
      return '0;
    end else if (roll == 3) begin
      return weight_t'($urandom_range(999, 1023));
    end else if (roll == 4) begin
      return weight_t'(998);
    end else if (roll < 10) begin
      return weight_t'($urandom_range(1, 6));
    end
    return weight_t'($urandom_range(1, 998));
  endfunction

  // write any entry of the active square that has never been loaded
  task automatic fill_square();
    for (int r = 0; r < span; r++) begin
      for (int c = 0; c < span; c++) begin
        if (!loaded[r][c]) begin
          write_weight(r, c, pick_weight());
        end
      end
    end
  endtask

  // Register write only with the core idle: input quiet, every predicted
  // word delivered, then a short settle for the last weight write.
  task automatic set_nodes(input count_t value);
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (value < NODE_COUNT_MIN) begin
      span = NODE_COUNT_MIN;
    end else if (value > HW_NODE_LIMIT) begin
      span = HW_NODE_LIMIT;
    end else begin
      span = value;
    end
  endtask

  // Result side: the stall mode is redrawn at random. A long hold-off
  // is armed at start (and now and then after a completed run) and fires on
  // the first word of a run, so the core stays busy and input backs up.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit armed;
    mode          = 0;
    mode_left     = 0;
    hold_left     = 0;
    armed         = 1'b1;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (rst_n && out_bus.valid && out_bus.ready && out_bus.last && !armed) begin
        armed = ($urandom_range(0, 5) == 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (rst_n && armed && out_bus.valid && out_bus.position == 0) begin
        armed     = 1'b0;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_bus.ready <= 1'b1;
          end
          1: begin
            out_bus.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_bus.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_bus.ready <= ~out_bus.ready;
          end
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int     phase_items;
    int     runs_left;
    count_t setting;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.kind   = KIND_WRITE;
    in_bus.row    = '0;
    in_bus.col    = '0;
    in_bus.weight = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // two nodes: the cheaper start wins
    set_nodes(count_t'(2));
    write_weight(0, 0, weight_t'(0));
    write_weight(0, 1, weight_t'(998));
    write_weight(1, 0, weight_t'(5));
    write_weight(1, 1, weight_t'(0));
    run_tour();
    // equal cost from both starts: start 0 is kept
    write_weight(1, 0, weight_t'(998));
    run_tour();
    // only start 1 completes
    write_weight(0, 1, weight_t'(0));
    run_tour();
    // weight above the cutoff is no edge: nothing completes
    write_weight(1, 0, weight_t'(1023));
    run_tour();
    // count below the minimum acts as two; 999 is still no edge
    set_nodes(count_t'(0));
    write_weight(1, 0, weight_t'(999));
    write_weight(0, 1, weight_t'(7));
    run_tour();
    // three nodes: ties on the pick and between starts, diagonal ignored
    set_nodes(count_t'(3));
    write_weight(0, 2, weight_t'(3));
    write_weight(1, 2, weight_t'(3));
    write_weight(2, 0, weight_t'(3));
    write_weight(2, 1, weight_t'(3));
    write_weight(2, 2, weight_t'(1));
    run_tour();

    // --- random phases ---
    // counts up to 8, below the minimum included, keep the square fills short
    for (int p = 0; p < 8; p++) begin
      setting = count_t'($urandom_range(0, 8));
      set_nodes(setting);
      fill_square();
      phase_items = 10;
      runs_left   = 4;
      for (int i = 0; i < phase_items; i++) begin
        if (runs_left > 0 && $urandom_range(0, 3) == 0) begin
          runs_left--;
          run_tour();
        end else if ($urandom_range(0, 4) != 0) begin
          // reshape the active square
          write_weight($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                       pick_weight());
        end else begin
          // anywhere in the matrix, including rows beyond the span
          write_weight($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
        end
      end
      run_tour();
    end

    // drain: every predicted word in, then a quiet tail for stray words
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/nnt_pkg.sv
design/nnt_in_if.sv
design/nnt_out_if.sv
design/nnt_matrix.sv
design/nnt_paths.sv
design/nnt_ctrl.sv
design/nearest_neighbour_tour_core.sv
tb/nnt_tour_checker.sv
tb/tb_nearest_neighbour_tour_core.sv
